// ----- rtl/eav_pkg.sv -----
package eav_pkg;

   localparam int MAX_LEN = 256;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);

   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   typedef struct packed {
      logic [CNT_W-1:0] byte_count;
      logic             in_domain;
      logic [1:0]       local_nondot_count;
      logic             local_atext_ok;
      logic             opens_with_quote;
      logic             quoted_inner_ok;
      logic             escape_pending;
      logic [7:0]       held_char;
      logic             domain_prev_dot;
      logic             domain_ok;
   } eav_state_type;

   localparam eav_state_type STATE_RST = '{
      byte_count:         '0,
      in_domain:          1'b0,
      local_nondot_count: 2'd0,
      local_atext_ok:     1'b1,
      opens_with_quote:   1'b0,
      quoted_inner_ok:    1'b1,
      escape_pending:     1'b0,
      held_char:          8'h00,
      domain_prev_dot:    1'b1,
      domain_ok:          1'b1
   };

   function automatic logic is_atext(input logic [7:0] b);
      logic hit;
      hit = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
            ((b >= 8'h30) && (b <= 8'h39));
      case (b)
         8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D, 8'h2F,
         8'h3D, 8'h3F, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E: hit = 1'b1;
         default: ;
      endcase
      return hit;
   endfunction

   function automatic logic is_sep(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT);
   endfunction

   function automatic logic base_ok(input logic [7:0] b);
      return (b != 8'h00) && !b[7] && (b != CH_LF) && (b != CH_CR);
   endfunction

endpackage

// ----- rtl/eav_step.sv -----
module eav_step
   import eav_pkg::*;
(
   input  eav_state_type state_cur,
   input  logic [7:0]    char_byte,
   input  logic          last_byte,
   output eav_state_type state_nxt,
   output logic          address_valid
);

   eav_state_type upd;
   logic          too_long;
   logic          atext_local;
   logic          quoted_local;

   always_comb begin
      upd      = state_cur;
      too_long = state_cur.byte_count >= CNT_W'(MAX_LEN);
      if (!too_long) begin
         upd.byte_count = state_cur.byte_count + 1'b1;
      end
      if (state_cur.in_domain) begin
         if (char_byte == CH_DOT) begin
            if (state_cur.domain_prev_dot) begin
               upd.domain_ok = 1'b0;
            end
            upd.domain_prev_dot = 1'b1;
         end else begin
            if (!is_atext(char_byte)) begin
               upd.domain_ok = 1'b0;
            end
            upd.domain_prev_dot = 1'b0;
         end
      end else if (char_byte == CH_AT) begin
         upd.in_domain = 1'b1;
      end else if (char_byte != CH_DOT) begin
         if (!is_atext(char_byte)) begin
            upd.local_atext_ok = 1'b0;
         end
         if (state_cur.local_nondot_count == 2'd0) begin
            upd.opens_with_quote = (char_byte == CH_QUOTE);
         end else if (state_cur.local_nondot_count == 2'd2) begin
            // previous byte is now known to be an inner byte
            if (state_cur.escape_pending) begin
               upd.escape_pending = 1'b0;
               if (!base_ok(state_cur.held_char) || is_sep(state_cur.held_char)) begin
                  upd.quoted_inner_ok = 1'b0;
               end
            end else if (is_sep(state_cur.held_char)) begin
               upd.escape_pending = 1'b0;
            end else if (state_cur.held_char == CH_BSL) begin
               upd.escape_pending = 1'b1;
            end else if (!base_ok(state_cur.held_char) ||
                         (state_cur.held_char == CH_QUOTE)) begin
               upd.quoted_inner_ok = 1'b0;
            end
         end
         upd.held_char = char_byte;
         if (state_cur.local_nondot_count != 2'd2) begin
            upd.local_nondot_count = state_cur.local_nondot_count + 2'd1;
         end
      end

      atext_local  = (upd.local_nondot_count != 2'd0) && upd.local_atext_ok;
      quoted_local = upd.opens_with_quote && (upd.local_nondot_count == 2'd2) &&
                     (upd.held_char == CH_QUOTE) && upd.quoted_inner_ok &&
                     !upd.escape_pending;
      address_valid = !too_long && upd.in_domain && (atext_local || quoted_local) &&
                      upd.domain_ok && !upd.domain_prev_dot;

      state_nxt = last_byte ? STATE_RST : upd;
   end

endmodule

// ----- rtl/email_address_validator_unit.sv -----
// result path: input register, then result register driving rsp_tvalid
// throughput: one byte per cycle; req_tready stays high while the result
// register is empty or being taken
// reset: synchronous, active high; clears the input and result registers and
// returns the address state to its start values
module email_address_validator_unit
   import eav_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] address_valid, [7:1] zero
);

   logic          a_valid_ff, a_valid_in;
   logic [7:0]    a_char_ff;
   logic          a_last_ff;
   eav_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_data_ff;
   logic          out_free;
   logic          a_go;
   logic          req_take;
   logic          verdict;

   eav_step u_step (
      .state_cur     (state_ff),
      .char_byte     (a_char_ff),
      .last_byte     (a_last_ff),
      .state_nxt     (state_in),
      .address_valid (verdict)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign a_go       = a_valid_ff && (!a_last_ff || out_free);
   assign req_tready = !a_valid_ff || a_go;
   assign req_take   = req_tvalid && req_tready;

   assign a_valid_in   = req_take || (a_valid_ff && !a_go);
   assign out_valid_in = (a_go && a_last_ff) || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RST;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
         if (a_go) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_char_ff <= req_tdata;
         a_last_ff <= req_tlast;
      end
      if (a_go && a_last_ff) begin
         out_data_ff <= verdict;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_data_ff};

endmodule

// ----- rtl/eav_checker.sv -----
module eav_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a waiting result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word right after reset");

   // a new result follows a last byte taken through the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result word without a last byte");

   // input never stalls while the result side is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

endmodule

bind email_address_validator_unit eav_checker u_eav_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- verif/email_address_validator_unit_test.sv -----
module email_address_validator_unit_test;
   import eav_pkg::*;

   localparam int RANDOM_WORDS = 1260;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 8;

   logic       clock;
   logic       reset;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   email_address_validator_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   string atext_pool =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!#$%&'*+-/=?^_`{|}~";

   logic [7:0] addr_buf[$];
   logic [8:0] pending_words[$];
   logic [7:0] verdicts_due[$];

   int  total_words = 0;
   int  words_in    = 0;
   int  failures    = 0;
   int  idle_cycles = 0;
   int  req_pause   = 0;
   int  rsp_hold    = 0;
   bit  steady_req  = 0;
   bit  steady_rsp  = 0;
   logic req_taken  = 1'b0;

   // running scan of the current address
   int         seen_len;
   bit         at_seen;
   int         core_len;
   bit         plain_local;
   bit         quote_open;
   bit         quote_clean;
   bit         esc_wait;
   logic [7:0] prior_char;
   bit         dom_after_dot;
   bit         dom_clean;

   function automatic bit atext_char(input logic [7:0] b);
      bit hit;
      hit = 1'b0;
      for (int i = 0; i < atext_pool.len(); i++)
         if (atext_pool[i] == b)
            hit = 1'b1;
      return hit;
   endfunction

   function automatic bit sep_char(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT);
   endfunction

   function automatic bit plain_char(input logic [7:0] b);
      return (b >= 8'h01) && (b <= 8'h7F) && (b != CH_LF) && (b != CH_CR);
   endfunction

   task automatic clear_scan();
      seen_len      = 0;
      at_seen       = 1'b0;
      core_len      = 0;
      plain_local   = 1'b1;
      quote_open    = 1'b0;
      quote_clean   = 1'b1;
      esc_wait      = 1'b0;
      prior_char    = 8'h00;
      dom_after_dot = 1'b1;
      dom_clean     = 1'b1;
   endtask

   task automatic absorb_char(input logic [7:0] b, input logic fin);
      bit overflow;
      bit plain_ok;
      bit quoted_ok;
      bit verdict;
      overflow = (seen_len >= MAX_LEN);
      if (!overflow)
         seen_len++;
      if (at_seen) begin
         if (b == CH_DOT) begin
            if (dom_after_dot)
               dom_clean = 1'b0;
            dom_after_dot = 1'b1;
         end else begin
            if (!atext_char(b))
               dom_clean = 1'b0;
            dom_after_dot = 1'b0;
         end
      end else if (b == CH_AT) begin
         at_seen = 1'b1;
      end else if (b != CH_DOT) begin
         if (!atext_char(b))
            plain_local = 1'b0;
         if (core_len == 0) begin
            quote_open = (b == CH_QUOTE);
         end else if (core_len >= 2) begin
            // the held byte is now known to be inside the quotes
            if (esc_wait) begin
               esc_wait = 1'b0;
               if (!plain_char(prior_char) || sep_char(prior_char))
                  quote_clean = 1'b0;
            end else if (prior_char == CH_BSL) begin
               esc_wait = 1'b1;
            end else if (!sep_char(prior_char)) begin
               if (!plain_char(prior_char) || prior_char == CH_QUOTE)
                  quote_clean = 1'b0;
            end
         end
         prior_char = b;
         if (core_len < 2)
            core_len++;
      end
      if (fin) begin
         plain_ok  = (core_len >= 1) && plain_local;
         quoted_ok = quote_open && (core_len >= 2) && (prior_char == CH_QUOTE) &&
                     quote_clean && !esc_wait;
         verdict   = !overflow && at_seen && (plain_ok || quoted_ok) && dom_clean &&
                     !dom_after_dot;
         verdicts_due.push_back({7'b0, verdict});
         clear_scan();
      end
   endtask

   function automatic logic [7:0] pick_atext();
      return atext_pool[$urandom_range(0, atext_pool.len() - 1)];
   endfunction

   function automatic logic [7:0] pick_sep();
      case ($urandom_range(0, 2))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         default: return CH_VT;
      endcase
   endfunction

   function automatic logic [7:0] odd_byte();
      case ($urandom_range(0, 15))
         0:       return CH_DOT;
         1:       return CH_AT;
         2:       return CH_QUOTE;
         3:       return CH_BSL;
         4:       return CH_SPACE;
         5:       return CH_TAB;
         6:       return CH_VT;
         7:       return CH_LF;
         8:       return CH_CR;
         9:       return 8'h00;
         10:      return 8'h7F;
         11:      return 8'h80;
         12:      return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int pick_gap(input bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 25);
   endfunction

   task automatic load_text(input string s);
      addr_buf.delete();
      for (int i = 0; i < s.len(); i++)
         addr_buf.push_back(s[i]);
   endtask

   task automatic commit_address();
      for (int i = 0; i < addr_buf.size(); i++)
         pending_words.push_back({(i == addr_buf.size() - 1), addr_buf[i]});
   endtask

   task automatic push_text(input string s);
      load_text(s);
      commit_address();
   endtask

   task automatic long_address(input int n);
      addr_buf.delete();
      repeat (n - 4)
         addr_buf.push_back(pick_atext());
      addr_buf.push_back(CH_AT);
      addr_buf.push_back("b");
      addr_buf.push_back(CH_DOT);
      addr_buf.push_back("c");
      commit_address();
   endtask

   task automatic gen_address();
      int kind;
      int n;
      addr_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         n = $urandom_range(1, 8);
         repeat (n) begin
            if ($urandom_range(0, 5) == 0)
               addr_buf.push_back(CH_DOT);
            addr_buf.push_back(pick_atext());
         end
         if ($urandom_range(0, 7) == 0)
            addr_buf.push_back(CH_DOT);
      end else if (kind < 75) begin
         addr_buf.push_back(CH_QUOTE);
         n = $urandom_range(0, 6);
         repeat (n) begin
            case ($urandom_range(0, 9))
               5: addr_buf.push_back(pick_sep());
               6: begin
                  addr_buf.push_back(CH_BSL);
                  case ($urandom_range(0, 3))
                     0:       addr_buf.push_back(CH_QUOTE);
                     1:       addr_buf.push_back(CH_BSL);
                     2:       addr_buf.push_back(odd_byte());
                     default: addr_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
                  endcase
               end
               7:       addr_buf.push_back(CH_DOT);
               8:       addr_buf.push_back(8'($urandom_range(8'h01, 8'h7F)));
               9:       addr_buf.push_back(odd_byte());
               default: addr_buf.push_back(pick_atext());
            endcase
         end
         addr_buf.push_back(CH_QUOTE);
      end else if (kind < 85) begin
         // noise
         n = $urandom_range(1, 12);
         repeat (n)
            addr_buf.push_back($urandom_range(0, 1) ? odd_byte() : pick_atext());
         commit_address();
         return;
      end else begin
         n = $urandom_range(1, 3);
         repeat (n)
            addr_buf.push_back($urandom_range(0, 2) ? pick_atext() : odd_byte());
      end
      if ($urandom_range(0, 19) != 0) begin
         addr_buf.push_back(CH_AT);
         n = $urandom_range(1, 3);
         for (int k = 0; k < n; k++) begin
            if (k > 0)
               addr_buf.push_back(CH_DOT);
            repeat ($urandom_range(1, 6))
               addr_buf.push_back(pick_atext());
         end
      end
      if ($urandom_range(0, 4) == 0)
         addr_buf[$urandom_range(0, addr_buf.size() - 1)] = odd_byte();
      commit_address();
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender
   always @(negedge clock) begin : drive_req
      logic [8:0] w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
      end else if (req_pause > 0) begin
         req_pause  <= req_pause - 1;
         req_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
         w = pending_words.pop_front();
         req_tdata  <= w[7:0];
         req_tlast  <= w[8];
         req_tvalid <= 1'b1;
         if ($urandom_range(0, 149) == 0)
            steady_req <= !steady_req;
         req_pause  <= pick_gap(steady_req);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver
   always @(negedge clock) begin : drive_rsp
      int r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!steady_rsp && $urandom_range(0, 7) == 0) begin
         r = $urandom_range(0, 99);
         rsp_tready <= 1'b0;
         rsp_hold   <= (r < 85) ? $urandom_range(0, 2) : $urandom_range(3, 24);
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 149) == 0)
            steady_rsp <= !steady_rsp;
      end
   end

   always @(posedge clock) begin : watch
      logic [7:0] want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            absorb_char(req_tdata, req_tlast);
            words_in++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: unexpected verdict word, expected none, got %h",
                        $time, rsp_tdata);
               failures++;
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_tdata[0] !== want[0] || rsp_tdata[7:1] !== want[7:1]) begin
                  $display("%0t: verdict mismatch, expected %h, got %h",
                           $time, want, rsp_tdata);
                  failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      clear_scan();

      push_text("a@b");
      push_text("a.b.c@d.e");
      push_text(".x.@y-z.q");
      push_text("ab");
      push_text("\"@b");
      push_text("@b");
      push_text("..@b");
      push_text("a@");
      push_text("a@.b");
      push_text("a@b.");
      push_text("a@b..c");
      push_text("a@b@c");
      push_text("a\"@b");
      push_text("\"a b\\\"c\"@x.y");
      push_text("\"\"@x");
      push_text("\"a.b\\\"@x");
      push_text("\"a\"b\"@x");
      push_text("\"\\ \"@x");
      push_text("\"a\tb\"@x");
      push_text("@");
      load_text("a?@b");
      addr_buf[1] = 8'h00;
      commit_address();
      load_text("\"\\?\"@b?c");
      addr_buf[2] = CH_LF;
      addr_buf[6] = 8'h00;
      commit_address();
      load_text("\"??\"@b");
      addr_buf[1] = 8'h7F;
      addr_buf[2] = 8'h01;
      commit_address();
      load_text("\"?\"@b");
      addr_buf[1] = 8'h80;
      commit_address();
      load_text("?@b");
      addr_buf[0] = 8'hFF;
      commit_address();
      long_address(MAX_LEN);
      long_address(MAX_LEN + 1);

      total_words = pending_words.size();
      while (pending_words.size() < total_words + RANDOM_WORDS) begin
         if ($urandom_range(0, 199) == 0)
            long_address($urandom_range(MAX_LEN - 2, MAX_LEN + 3));
         else
            gen_address();
      end
      total_words = pending_words.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (words_in != total_words || verdicts_due.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/eav_pkg.sv
rtl/eav_step.sv
rtl/email_address_validator_unit.sv
rtl/eav_checker.sv
verif/email_address_validator_unit_test.sv
